### hw/rtl/rcas_pkg.sv
// Shared types and constants for the RC arming and set-point unit.
// Used by every module in hw/rtl; depends on nothing else.
package rcas_pkg;

    localparam int PULSE_BITS = 16;
    localparam int FIELD_BITS = 16;
    localparam int SEC_BITS   = 16;
    localparam int SP_BITS    = 24;
    localparam int DZ_BITS    = 9;
    localparam int HOLD_BITS  = 8;
    localparam int CFG_BITS   = 9;

    localparam logic [PULSE_BITS-1:0] ROLL_CENTRE  = PULSE_BITS'(1507);
    localparam logic [PULSE_BITS-1:0] PITCH_CENTRE = PULSE_BITS'(1508);
    localparam logic [PULSE_BITS-1:0] THR_LOW      = PULSE_BITS'(1100);
    localparam logic [PULSE_BITS-1:0] YAW_HIGH     = PULSE_BITS'(1900);

    // 0.0361446 deg/us in 1/256 degree, Q16
    localparam int SCALE_BITS = 20;
    localparam int SCALE_FRAC = 16;
    localparam logic [SCALE_BITS-1:0] SCALE_Q16 = SCALE_BITS'(606406);

    localparam logic [DZ_BITS-1:0]   DZ_RESET     = DZ_BITS'(20);
    localparam logic [HOLD_BITS-1:0] ARM_RESET    = HOLD_BITS'(5);
    localparam logic [HOLD_BITS-1:0] DISARM_RESET = HOLD_BITS'(8);

    typedef enum logic [1:0] {
        CFG_DEADZONE    = 2'd0,
        CFG_ARM_HOLD    = 2'd1,
        CFG_DISARM_HOLD = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [SEC_BITS-1:0]   now_seconds;
        logic [FIELD_BITS-1:0] yaw_pulse;
        logic [FIELD_BITS-1:0] throttle_pulse;
        logic [FIELD_BITS-1:0] pitch_pulse;
        logic [FIELD_BITS-1:0] roll_pulse;
    } item_t;

    typedef struct packed {
        logic signed [SP_BITS-1:0] pitch_target;
        logic signed [SP_BITS-1:0] roll_target;
        logic [FIELD_BITS-1:0]     throttle_command;
        logic                      motors_enabled;
        logic                      is_armed;
    } result_t;

    localparam int S_DATA_BITS = (($bits(item_t) + 7) / 8) * 8;
    localparam int RESULT_BITS = $bits(result_t);
    localparam int M_DATA_BITS = ((RESULT_BITS + 7) / 8) * 8;

endpackage

### hw/rtl/rcas_axis_scale.sv
// Stick offset to attitude set-point: deadzone test, Q16 scale, round half away.
// Depends on rcas_pkg.
module rcas_axis_scale
    import rcas_pkg::*;
(
    input  logic [PULSE_BITS-1:0]    pulse,
    input  logic [PULSE_BITS-1:0]    centre,
    input  logic                     invert,
    input  logic [DZ_BITS-1:0]       deadzone,
    output logic signed [SP_BITS-1:0] setpoint
);

    localparam int PROD_BITS = PULSE_BITS + SCALE_BITS;

    logic [PULSE_BITS:0]     diff;
    logic                    below;
    logic [PULSE_BITS-1:0]   mag;
    logic                    in_dz;
    logic                    neg;
    logic [PROD_BITS-1:0]    prod;
    logic [PROD_BITS:0]      rounded;
    logic [SP_BITS-1:0]      q_ext;

    assign diff  = {1'b0, pulse} - {1'b0, centre};
    assign below = diff[PULSE_BITS];
    assign mag   = below ? PULSE_BITS'(centre - pulse) : diff[PULSE_BITS-1:0];
    assign in_dz = mag <= PULSE_BITS'(deadzone);
    assign neg   = invert ? !below : below;
    assign prod  = PROD_BITS'(mag) * PROD_BITS'(SCALE_Q16);
    assign rounded = {1'b0, prod} + (PROD_BITS+1)'(1 << (SCALE_FRAC - 1));
    assign q_ext = SP_BITS'(rounded[PROD_BITS:SCALE_FRAC]);

    always_comb
    begin
        if (in_dz)
        begin
            setpoint = '0;
        end
        else if (neg)
        begin
            setpoint = -$signed(q_ext);
        end
        else
        begin
            setpoint = $signed(q_ext);
        end
    end

endmodule

### hw/rtl/rcas_arm_core.sv
// Arming state, hold timers, set-point state, configuration and result register.
// Depends on rcas_pkg and rcas_axis_scale.
module rcas_arm_core
    import rcas_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_addr,
    input  logic [CFG_BITS-1:0] cfg_wdata,
    input  logic                in_valid,
    input  item_t               in_item,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output result_t             out_data
);

    logic [DZ_BITS-1:0]       dz_reg;
    logic [HOLD_BITS-1:0]     arm_hold_reg;
    logic [HOLD_BITS-1:0]     disarm_hold_reg;

    logic                     armed_reg, armed_next;
    logic [SEC_BITS-1:0]      arm_start_reg, arm_start_next;
    logic [SEC_BITS-1:0]      disarm_start_reg, disarm_start_next;
    logic signed [SP_BITS-1:0] roll_sp_reg, roll_sp_next;
    logic signed [SP_BITS-1:0] pitch_sp_reg, pitch_sp_next;
    logic                     out_valid_reg;
    result_t                  out_data_reg, out_data_next;

    logic                     adv;
    logic [PULSE_BITS-1:0]    roll, pitch, thr, yaw;
    logic [SEC_BITS-1:0]      now;
    logic                     thr_hi, thr_lo, yaw_lo, yaw_hi, motors;
    logic [SEC_BITS-1:0]      arm_eff, disarm_eff;
    logic                     arm_done, disarm_done;
    logic signed [SP_BITS-1:0] roll_scaled, pitch_scaled;

    assign in_ready  = !out_valid_reg || out_ready;
    assign adv       = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign roll  = in_item.roll_pulse[PULSE_BITS-1:0];
    assign pitch = in_item.pitch_pulse[PULSE_BITS-1:0];
    assign thr   = in_item.throttle_pulse[PULSE_BITS-1:0];
    assign yaw   = in_item.yaw_pulse[PULSE_BITS-1:0];
    assign now   = in_item.now_seconds;

    assign thr_hi = thr > THR_LOW;
    assign thr_lo = thr < THR_LOW;
    assign yaw_lo = yaw < THR_LOW;
    assign yaw_hi = yaw > YAW_HIGH;

    assign arm_eff     = (arm_start_reg == '0) ? now : arm_start_reg;
    assign disarm_eff  = (disarm_start_reg == '0) ? now : disarm_start_reg;
    assign arm_done    = SEC_BITS'(now - arm_eff) >= SEC_BITS'(arm_hold_reg);
    assign disarm_done = SEC_BITS'(now - disarm_eff) >= SEC_BITS'(disarm_hold_reg);

    rcas_axis_scale u_roll_scale (
        .pulse    (roll),
        .centre   (ROLL_CENTRE),
        .invert   (1'b0),
        .deadzone (dz_reg),
        .setpoint (roll_scaled)
    );

    rcas_axis_scale u_pitch_scale (
        .pulse    (pitch),
        .centre   (PITCH_CENTRE),
        .invert   (1'b1),
        .deadzone (dz_reg),
        .setpoint (pitch_scaled)
    );

    always_comb
    begin
        armed_next        = armed_reg;
        arm_start_next    = arm_start_reg;
        disarm_start_next = disarm_start_reg;
        roll_sp_next      = roll_sp_reg;
        pitch_sp_next     = pitch_sp_reg;
        if (armed_reg)
        begin
            if (thr_hi)
            begin
                roll_sp_next  = roll_scaled;
                pitch_sp_next = pitch_scaled;
            end
            if (thr_lo && yaw_lo)
            begin
                disarm_start_next = disarm_eff;
                if (disarm_done)
                begin
                    armed_next = 1'b0;
                end
            end
            else
            begin
                disarm_start_next = '0;
            end
        end
        else
        begin
            if (thr_lo && yaw_hi)
            begin
                arm_start_next = arm_eff;
                if (arm_done)
                begin
                    armed_next = 1'b1;
                end
            end
            else
            begin
                arm_start_next = '0;
            end
        end
    end

    assign motors = armed_next && thr_hi;

    always_comb
    begin
        out_data_next.is_armed         = armed_next;
        out_data_next.motors_enabled   = motors;
        out_data_next.throttle_command = motors ? FIELD_BITS'(thr) : '0;
        out_data_next.roll_target      = roll_sp_next;
        out_data_next.pitch_target     = pitch_sp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dz_reg          <= DZ_RESET;
            arm_hold_reg    <= ARM_RESET;
            disarm_hold_reg <= DISARM_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                CFG_DEADZONE:    dz_reg          <= cfg_wdata[DZ_BITS-1:0];
                CFG_ARM_HOLD:    arm_hold_reg    <= cfg_wdata[HOLD_BITS-1:0];
                CFG_DISARM_HOLD: disarm_hold_reg <= cfg_wdata[HOLD_BITS-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg        <= 1'b0;
            arm_start_reg    <= '0;
            disarm_start_reg <= '0;
            roll_sp_reg      <= '0;
            pitch_sp_reg     <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                armed_reg        <= armed_next;
                arm_start_reg    <= arm_start_next;
                disarm_start_reg <= disarm_start_next;
                roll_sp_reg      <= roll_sp_next;
                pitch_sp_reg     <= pitch_sp_next;
                out_valid_reg    <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= out_data_next;
        end
    end

    a_disarm_needs_gesture: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(armed_reg) |-> $past(adv && thr_lo && yaw_lo))
        else $error("disarmed without the disarming gesture");

    a_arm_needs_gesture: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(armed_reg) |-> $past(adv && thr_lo && yaw_hi))
        else $error("armed without the arming gesture");

    a_sp_moves_when_flying: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(roll_sp_reg) |-> $past(adv && armed_reg && thr_hi))
        else $error("roll set-point changed outside armed flight");

    a_motors_need_arm: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.motors_enabled |-> out_data_reg.is_armed)
        else $error("motors enabled while disarmed");

    a_throttle_gated: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_data_reg.motors_enabled |-> out_data_reg.throttle_command == '0)
        else $error("throttle command passed with motors off");

endmodule

### hw/rtl/rc_arming_and_setpoint_unit.sv
// RC arming and set-point unit: input register, stream packing, core instance.
// Depends on rcas_pkg and rcas_arm_core.
//
// One control tick enters per s_tdata transaction: roll, pitch, throttle and yaw
// pulse widths in microseconds and the seconds count. Each tick yields exactly
// one m_tdata transaction: armed flag, motor enable, gated throttle and the roll
// and pitch set-points in 1/256 degree.
// The configuration port writes the deadzone (index 0), the arming hold
// seconds (1) and the disarming hold seconds (2); write only while
// no tick is in flight.
// An accepted s_tdata tick passes through the input register, then the arming
// logic and set-point multipliers feeding the result register, to m_tvalid.
// While m_tready is high it takes one tick per cycle; the hold timers and set-points update in
// the same cycle the result register loads, so consecutive ticks chain fully.
// Reset disarms the block, clears both hold timers and set-points and loads
// the configuration defaults (deadzone 20, arm hold 5, disarm hold 8).
// When m_tready is low the result register holds, the input register holds its
// tick, and s_tready drops once both are full.
module rc_arming_and_setpoint_unit
    import rcas_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [1:0]             cfg_addr,
    input  logic [CFG_BITS-1:0]    cfg_wdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // roll_pulse, pitch_pulse, throttle_pulse, yaw_pulse, now_seconds
    input  logic [S_DATA_BITS-1:0] s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // is_armed, motors_enabled, throttle_command, roll_target, pitch_target, zero pad
    output logic [M_DATA_BITS-1:0] m_tdata
);

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    core_ready;
    result_t core_data;

    assign s_tready = !in_valid_reg || core_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg <= item_t'(s_tdata[$bits(item_t)-1:0]);
        end
    end

    rcas_arm_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid_reg),
        .in_item   (in_item_reg),
        .in_ready  (core_ready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (core_data)
    );

    assign m_tdata = M_DATA_BITS'(core_data);

endmodule
